/* sv/str_pkg.sv */
// ----------------------------------------------------------------------------
// str_pkg - sorted key table shared definitions
// Command and status codes, request and response beat types, default depth.
// ----------------------------------------------------------------------------
package str_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int KEY_W               = 32;
   localparam int POS_W               = 10;
   localparam int CNT_W               = 11;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_DUP        = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_NEW_EXISTS = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type                   command;
      logic signed [KEY_W-1:0]   key;
      logic signed [KEY_W-1:0]   new_key;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          position;
      logic [CNT_W-1:0]          entry_count;
   } rsp_type;

endpackage

/* sv/str_ram.sv */
// ----------------------------------------------------------------------------
// str_ram - generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module str_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sorted_table_insert_delete_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_search - sorted key table with binary search
// Query: a binary search over the entries, then the result strobe.
// Delete moves the later entries down; insert moves entries up, then writes.
// Update runs two searches and both moves.
// One item at a time; busy drops with the strobe, which cannot be stalled.
// Reset clears the state, the count and the flags; the key RAM is left as it is.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_search #(
   parameter int TABLE_DEPTH = str_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  str_pkg::req_type req_item,
   output logic             rsp_valid,
   output str_pkg::rsp_type rsp_item
);

   import str_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_CHECK,
      S_SHIFT_DN,
      S_SHIFT_UP,
      S_INS_WR
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] nkey_ff, nkey_in;
   logic signed [KEY_W-1:0] tgt_ff, tgt_in;
   logic signed [KEY_W-1:0] ins_key_ff, ins_key_in;
   logic                    phase_ff, phase_in;
   logic                    chain_ff, chain_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic [CW-1:0]           mid_ff, mid_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           ins_pos_ff, ins_pos_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pend_addr_ff, pend_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [CW-1:0]           mid;
   logic [CW-1:0]           idx_dec;
   logic [CW-1:0]           lo_dec;
   logic                    found;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [KEY_W-1:0]        ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [KEY_W-1:0]        ram_rd_data;

   str_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - 1'b1;
   assign lo_dec  = lo_ff - 1'b1;
   assign found   = (lo_ff < count_ff) && ($signed(ram_rd_data) == tgt_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      nkey_in      = nkey_ff;
      tgt_in       = tgt_ff;
      ins_key_in   = ins_key_ff;
      phase_in     = phase_ff;
      chain_in     = chain_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      ins_pos_in   = ins_pos_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      ram_rd_addr  = '0;
      ram_wr_en    = pend_ff;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = ram_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_item.command;
               key_in   = req_item.key;
               nkey_in  = req_item.new_key;
               tgt_in   = req_item.key;
               phase_in = 1'b0;
               chain_in = 1'b0;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_addr = mid[AW-1:0];
               mid_in      = mid;
               state_in    = S_COMPARE;
            end else begin
               ram_rd_addr = lo_ff[AW-1:0];
               state_in    = S_CHECK;
            end
         end
         S_COMPARE: begin
            if ($signed(ram_rd_data) < tgt_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            rsp_in.position    = '0;
            rsp_in.entry_count = CNT_W'(count_ff);
            if (phase_ff) begin
               if (found) begin
                  rsp_in.status = ST_NEW_EXISTS;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  // new slot, seen from the table after the old key is gone
                  ins_pos_in = (lo_ff > pos_ff) ? lo_dec : lo_ff;
                  ins_key_in = nkey_ff;
                  chain_in   = 1'b1;
                  idx_in     = pos_ff + 1'b1;
                  state_in   = S_SHIFT_DN;
               end
            end else begin
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     if (found) begin
                        rsp_in.status = ST_DUP;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end else if (count_ff == CW'(TABLE_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end else begin
                        ins_pos_in = lo_ff;
                        ins_key_in = key_ff;
                        idx_in     = count_ff;
                        state_in   = S_SHIFT_UP;
                     end
                  end
                  CMD_DELETE: begin
                     if (found) begin
                        idx_in   = lo_ff + 1'b1;
                        state_in = S_SHIFT_DN;
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
                  CMD_UPDATE: begin
                     if (found) begin
                        pos_in   = lo_ff;
                        phase_in = 1'b1;
                        tgt_in   = nkey_ff;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = S_SEARCH;
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
                  CMD_QUERY: begin
                     if (found) begin
                        rsp_in.status   = ST_OK;
                        rsp_in.position = POS_W'(lo_ff);
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SHIFT_DN: begin
            // read entry idx, write it one place lower on the next cycle
            if (idx_ff < count_ff) begin
               ram_rd_addr  = idx_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_dec[AW-1:0];
               idx_in       = idx_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (chain_ff) begin
                  idx_in   = count_ff - 1'b1;
                  state_in = S_SHIFT_UP;
               end else begin
                  rsp_in.status      = ST_OK;
                  rsp_in.position    = '0;
                  rsp_in.entry_count = CNT_W'(count_ff - 1'b1);
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end
            end
         end
         S_SHIFT_UP: begin
            // read entry idx-1, write it at idx on the next cycle
            if (idx_ff > ins_pos_ff) begin
               ram_rd_addr  = idx_dec[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_dec;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = ins_pos_ff[AW-1:0];
            ram_wr_data        = ins_key_ff;
            count_in           = count_ff + 1'b1;
            rsp_in.status      = ST_OK;
            rsp_in.position    = '0;
            rsp_in.entry_count = CNT_W'(count_ff + 1'b1);
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         chain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         chain_ff     <= chain_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      nkey_ff      <= nkey_in;
      tgt_ff       <= tgt_in;
      ins_key_ff   <= ins_key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      pos_ff       <= pos_in;
      ins_pos_ff   <= ins_pos_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not make the block busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == ST_FULL) |-> count_ff == CW'(TABLE_DEPTH))
      else $error("table full reported while not full");

   a_pend_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SHIFT_DN) || (state_ff == S_SHIFT_UP))
      else $error("pending move write outside a shift");
`endif

endmodule
